// ===== sv/set_union_intersection_assert.svh =====
// assertion macros for the set union / intersection block
`ifndef SET_UNION_INTERSECTION_ASSERT_SVH
`define SET_UNION_INTERSECTION_ASSERT_SVH

// same-cycle implication, clocked on clock, disabled in reset
`define SUI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, disabled in reset
`define SUI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sui_pkg.sv =====
// shared constants and types for the set union / intersection block
package sui_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CMD_W  = 3;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNION  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INTER  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
   } op_type;

endpackage

// ===== sv/sui_if.sv =====
// request and response channel interfaces
interface sui_req_if;
   logic                              valid;
   logic                              ready;
   logic [sui_pkg::CMD_W-1:0]         cmd;
   logic signed [sui_pkg::DATA_W-1:0] value;

   modport source (output valid, cmd, value, input ready);
   modport sink (input valid, cmd, value, output ready);
endinterface

interface sui_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sui_pkg::DATA_W-1:0] value_out;
   logic                              which_result;
   logic                              last;
   logic                              empty_res;
   logic                              overflow;

   modport source (output valid, value_out, which_result, last, empty_res, overflow,
                   input ready);
   modport sink (input valid, value_out, which_result, last, empty_res, overflow,
                 output ready);
endinterface

// ===== sv/sui_front.sv =====
// front end: accepts request words and drops unused command codes
module sui_front (
   sui_req_if.sink          req_if,
   output logic             push_valid,
   input  logic             push_ready,
   output sui_pkg::op_type  push_op
);

   logic legal;

   // codes above clear mean nothing and are swallowed here
   assign legal         = (req_if.cmd <= sui_pkg::CMD_CLEAR);
   assign req_if.ready  = push_ready;
   assign push_valid    = req_if.valid && legal;
   assign push_op.cmd   = req_if.cmd;
   assign push_op.value = req_if.value;

endmodule

// ===== sv/sui_queue.sv =====
// small command queue between front and back
module sui_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  sui_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output sui_pkg::op_type pop_op
);

   sui_pkg::op_type                 slot_ff [sui_pkg::QUEUE_DEPTH];
   logic [sui_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sui_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sui_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign push_ready = (count_ff != sui_pkg::QCNT_W'(sui_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + sui_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + sui_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + sui_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - sui_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== sv/sui_back.sv =====
// back end: list storage, union and intersection scans, response register
module sui_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  sui_pkg::op_type pop_op,
   sui_rsp_if.source       rsp_if
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_USCAN = 3'd1;
   localparam logic [2:0] ST_IOUT  = 3'd2;
   localparam logic [2:0] ST_IIN   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   localparam int unsigned CW = sui_pkg::CNT_W;
   localparam int unsigned IW = sui_pkg::IDX_W;
   localparam int unsigned DW = sui_pkg::DATA_W;

   logic signed [DW-1:0] mem_a [sui_pkg::DEPTH];
   logic signed [DW-1:0] mem_b [sui_pkg::DEPTH];
   logic signed [DW-1:0] rd_a_ff, rd_b_ff;
   logic [IW-1:0]        addr_a, addr_b;
   logic                 wr_a, wr_b;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic                 flag_ff, flag_in;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in, rv_idx_ff, rv_idx_in;
   logic                 rv_ff, rv_in;
   logic                 inter_ff, inter_in, swap_ff, swap_in;
   logic                 have_prev_ff, have_prev_in;
   logic signed [DW-1:0] prev_ff, prev_in, best_ff, best_in;
   logic                 found_ff, found_in, hit_ff, hit_in;
   logic                 pend_ff, pend_in;
   logic signed [DW-1:0] pend_val_ff, pend_val_in;

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_val_ff;
   logic                 rsp_last_ff, rsp_empty_ff, rsp_which_ff, rsp_ovf_ff;
   logic                 out_load, out_last, out_empty, out_free;
   logic signed [DW-1:0] out_val;

   logic                 a_ok, b_ok, c_ok, issuing;
   logic signed [DW-1:0] cand;
   logic [CW-1:0]        scan_cnt, probe_cnt;
   logic signed [DW-1:0] rd_scan, rd_probe;
   logic                 take_ok;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign pop_ready = (state_ff == ST_IDLE);

   assign scan_cnt  = swap_ff ? cnt_b_ff : cnt_a_ff;
   assign probe_cnt = swap_ff ? cnt_a_ff : cnt_b_ff;
   assign rd_scan   = swap_ff ? rd_b_ff : rd_a_ff;
   assign rd_probe  = swap_ff ? rd_a_ff : rd_b_ff;

   // scan side reads at the outer index, everything else at the inner one
   assign addr_a = (inter_ff && !swap_ff) ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign addr_b = (inter_ff && swap_ff) ? i_ff[IW-1:0] : j_ff[IW-1:0];

   assign wr_a = (state_ff == ST_IDLE) && pop_valid && (pop_op.cmd == sui_pkg::CMD_LOAD_A)
                 && (cnt_a_ff < sui_pkg::DEPTH_CNT);
   assign wr_b = (state_ff == ST_IDLE) && pop_valid && (pop_op.cmd == sui_pkg::CMD_LOAD_B)
                 && (cnt_b_ff < sui_pkg::DEPTH_CNT);

   // union candidates: smallest stored value above the last one emitted
   always_comb begin
      a_ok = rv_ff && (rv_idx_ff < cnt_a_ff) && (!have_prev_ff || (rd_a_ff > prev_ff));
      b_ok = rv_ff && (rv_idx_ff < cnt_b_ff) && (!have_prev_ff || (rd_b_ff > prev_ff));
      c_ok = a_ok || b_ok;
      if (a_ok && b_ok) begin
         cand = (rd_b_ff < rd_a_ff) ? rd_b_ff : rd_a_ff;
      end else if (b_ok) begin
         cand = rd_b_ff;
      end else begin
         cand = rd_a_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      flag_in      = flag_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rv_in        = 1'b0;
      rv_idx_in    = j_ff;
      inter_in     = inter_ff;
      swap_in      = swap_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      pend_val_in  = pend_val_ff;
      out_load     = 1'b0;
      out_val      = pend_val_ff;
      out_last     = 1'b0;
      out_empty    = 1'b0;
      issuing      = 1'b0;
      // a held item goes out only once the next one is known
      take_ok      = !pend_ff || out_free;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_op.cmd)
                  sui_pkg::CMD_LOAD_A: begin
                     if (cnt_a_ff < sui_pkg::DEPTH_CNT) begin
                        cnt_a_in = cnt_a_ff + CW'(1);
                     end else begin
                        flag_in = 1'b1;
                     end
                  end
                  sui_pkg::CMD_LOAD_B: begin
                     if (cnt_b_ff < sui_pkg::DEPTH_CNT) begin
                        cnt_b_in = cnt_b_ff + CW'(1);
                     end else begin
                        flag_in = 1'b1;
                     end
                  end
                  sui_pkg::CMD_UNION: begin
                     inter_in     = 1'b0;
                     swap_in      = 1'b0;
                     j_in         = '0;
                     found_in     = 1'b0;
                     have_prev_in = 1'b0;
                     pend_in      = 1'b0;
                     state_in     = ST_USCAN;
                  end
                  sui_pkg::CMD_INTER: begin
                     inter_in = 1'b1;
                     swap_in  = (cnt_b_ff > cnt_a_ff);
                     i_in     = '0;
                     pend_in  = 1'b0;
                     state_in = ST_IOUT;
                  end
                  sui_pkg::CMD_CLEAR: begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_USCAN: begin
            issuing = (j_ff < sui_pkg::DEPTH_CNT);
            if (issuing) begin
               j_in  = j_ff + CW'(1);
               rv_in = 1'b1;
            end
            if (c_ok && (!found_ff || (cand < best_ff))) begin
               best_in  = cand;
               found_in = 1'b1;
            end
            if (!issuing && !rv_ff) begin
               if (!found_ff) begin
                  state_in = ST_FIN;
               end else if (take_ok) begin
                  out_load     = pend_ff;
                  pend_in      = 1'b1;
                  pend_val_in  = best_ff;
                  prev_in      = best_ff;
                  have_prev_in = 1'b1;
                  found_in     = 1'b0;
                  j_in         = '0;
                  rv_in        = 1'b0;
               end
            end
         end

         ST_IOUT: begin
            if (i_ff == scan_cnt) begin
               state_in = ST_FIN;
            end else begin
               j_in     = '0;
               hit_in   = 1'b0;
               state_in = ST_IIN;
            end
         end

         ST_IIN: begin
            issuing = (j_ff < probe_cnt);
            if (issuing) begin
               j_in  = j_ff + CW'(1);
               rv_in = 1'b1;
            end
            if (rv_ff && (rd_probe == rd_scan)) begin
               hit_in = 1'b1;
            end
            if (!issuing && !rv_ff) begin
               if (!hit_ff) begin
                  i_in     = i_ff + CW'(1);
                  state_in = ST_IOUT;
               end else if (take_ok) begin
                  out_load    = pend_ff;
                  pend_in     = 1'b1;
                  pend_val_in = rd_scan;
                  i_in        = i_ff + CW'(1);
                  state_in    = ST_IOUT;
               end
            end
         end

         ST_FIN: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_last  = 1'b1;
               out_empty = !pend_ff;
               out_val   = pend_ff ? pend_val_ff : '0;
               pend_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[cnt_a_ff[IW-1:0]] <= pop_op.value;
      end
      rd_a_ff <= mem_a[addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[cnt_b_ff[IW-1:0]] <= pop_op.value;
      end
      rd_b_ff <= mem_b[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         flag_ff      <= 1'b0;
         rv_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         inter_ff     <= 1'b0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         flag_ff  <= flag_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
         inter_ff <= inter_in;
         swap_ff  <= swap_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      rv_idx_ff    <= rv_idx_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      pend_val_ff  <= pend_val_in;
      if (out_load) begin
         rsp_val_ff   <= out_val;
         rsp_last_ff  <= out_last;
         rsp_empty_ff <= out_empty;
         rsp_which_ff <= inter_ff;
         rsp_ovf_ff   <= flag_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.value_out    = rsp_val_ff;
   assign rsp_if.last         = rsp_last_ff;
   assign rsp_if.empty_res    = rsp_empty_ff;
   assign rsp_if.which_result = rsp_which_ff;
   assign rsp_if.overflow     = rsp_ovf_ff;

endmodule

// ===== sv/set_union_intersection.sv =====
// top level of the set union / intersection block
// Load words (first or second list) and clear take one cycle each in the back end once they
// leave the four-entry command queue; a request is accepted whenever that queue has room.
// A union run repeats a scan of both lists, one entry of each per cycle through their
// registered read ports, finding the next larger value; it takes one scan per emitted
// value plus one. An intersection run reads each entry of the longer list and compares
// it against the shorter list one entry a cycle. Each response word is held back in a
// pending register until the next one is found or the run ends, so that the last word
// can be marked; an empty result gives one word with empty_res set.
module set_union_intersection (
   input  logic      clock,
   input  logic      reset,
   sui_req_if.sink   req_if,
   sui_rsp_if.source rsp_if
);

   logic            push_valid, push_ready, pop_valid, pop_ready;
   sui_pkg::op_type push_op, pop_op;

   sui_front u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   sui_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   sui_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== sv/sui_checker.sv =====
// response port checks for the set union / intersection block
`include "set_union_intersection_assert.svh"

module sui_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [sui_pkg::DATA_W-1:0] rsp_value_out,
   input logic                              rsp_which_result,
   input logic                              rsp_last,
   input logic                              rsp_empty_res,
   input logic                              rsp_overflow
);

   logic run_ff, run_in;
   logic run_which_ff, run_which_in;
   logic run_ovf_ff, run_ovf_in;

   // track an open run: a word taken without last
   always_comb begin
      run_in       = run_ff;
      run_which_in = run_which_ff;
      run_ovf_in   = run_ovf_ff;
      if (rsp_valid && rsp_ready) begin
         run_in       = !rsp_last;
         run_which_in = rsp_which_result;
         run_ovf_in   = rsp_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         run_which_ff <= 1'b0;
         run_ovf_ff   <= 1'b0;
      end else begin
         run_ff       <= run_in;
         run_which_ff <= run_which_in;
         run_ovf_ff   <= run_ovf_in;
      end
   end

   `SUI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_out) && $stable(rsp_last), "response word changed while stalled")
   `SUI_ASSERT_SAME(a_empty_form, rsp_valid && rsp_empty_res, rsp_last && (rsp_value_out == 0), "empty result not a single zero word")
   `SUI_ASSERT_SAME(a_run_kind, rsp_valid && run_ff, (rsp_which_result == run_which_ff) && !rsp_empty_res, "result kind changed inside a run")
   `SUI_ASSERT_SAME(a_run_ovf, rsp_valid && run_ff && run_ovf_ff, rsp_overflow, "overflow dropped inside a run")

endmodule

bind set_union_intersection sui_checker u_sui_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_value_out    (rsp_if.value_out),
   .rsp_which_result (rsp_if.which_result),
   .rsp_last         (rsp_if.last),
   .rsp_empty_res    (rsp_if.empty_res),
   .rsp_overflow     (rsp_if.overflow)
);
